// ----- design/assert_macros.svh -----
// Assertion macros shared by the translation table RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: always");

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- design/nptl_pkg.sv -----
// Shared types and constants of the port translation table.
// No dependencies; used by the memories and the top level.
package nptl_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int CNT_W     = SLOT_W + 1;

  localparam logic [16:0] PORT_SPACE       = 17'h10000;
  localparam logic [15:0] FIRST_PORT_RESET = 16'd64512;

  localparam logic [1:0] OP_OUT = 2'd0;
  localparam logic [1:0] OP_IN  = 2'd1;
  localparam logic [1:0] OP_REL = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_MISS  = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;
  localparam logic [1:0] ST_REL   = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic REG_FIRST_PORT = 1'b0;
  localparam logic REG_LOCAL_ADDR = 1'b1;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  client;
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [15:0] port;
  } slot_t;

  typedef struct packed {
    slot_idx_t next;
    slot_idx_t prev;
  } link_t;

  typedef struct packed {
    logic      en;
    logic      we;
    slot_idx_t addr;
    slot_t     wdata;
  } slot_req_t;

  typedef struct packed {
    logic      en;
    logic      we_prev;
    logic      we_next;
    slot_idx_t addr;
    link_t     wdata;
  } link_req_t;

endpackage

// ----- design/nptl_slot_ram.sv -----
// Slot memory: one mapping per translated port, single port, registered read.
// Depends on nptl_pkg.
module nptl_slot_ram import nptl_pkg::*; (
  input  logic      clk,
  input  slot_req_t req,
  output slot_t     rdata
);

  slot_t mem [POOL_SIZE];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ----- design/nptl_link_ram.sv -----
// Recency list memory: prev and next links per slot with per-field write.
// Depends on nptl_pkg.
module nptl_link_ram import nptl_pkg::*; (
  input  logic      clk,
  input  link_req_t req,
  output link_t     rdata
);

  link_t mem [POOL_SIZE];

  // Write selected fields, else read the whole entry
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we_prev || req.we_next) begin
        if (req.we_prev) mem[req.addr].prev <= req.wdata.prev;
        if (req.we_next) mem[req.addr].next <= req.wdata.next;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule

// ----- design/nat_port_table_lru.sv -----
// Port translation table with least-recently-used reuse of translated ports.
// One request is handled at a time. Outbound requests scan the allocated
// slots of the slot memory for a match and allocate a slot if none is found.
// Inbound requests read the one slot that the port selects. A release scans
// every allocated slot and moves each freed slot that is not already at the
// front to the front. The single-port slot and link memories serialise this
// work. The next request is taken as soon as the previous result sits in the
// output register. No clearing pass is needed: slots at or above the
// allocation count are never read.
`include "assert_macros.svh"

module nat_port_table_lru import nptl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // client_id[3:0], protocol[11:4], address[43:12], port[59:44]
  input  logic [1:0]  s_tuser,   // operation
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // out_client[3:0], out_address[35:4], out_port[51:36]
  output logic [1:0]  m_tuser    // status
);

  typedef enum logic [4:0] {
    S_IDLE, S_OB_RD, S_OB_CHK, S_ALLOC, S_WR_SLOT, S_IN_RD, S_IN_CHK,
    S_RL_RD, S_RL_CHK, S_RL_CLR, S_MV0, S_MV1, S_MV2, S_LF0, S_LF1, S_DONE
  } state_t;

  state_t state, ret;

  logic [15:0] first_port;
  logic [31:0] local_address;

  logic [3:0]  cl;
  logic [7:0]  pr;
  logic [31:0] ad;
  logic [15:0] po;

  logic [CNT_W-1:0] count, scan;
  slot_idx_t        tgt, head, tail, lp, ln;
  slot_t            hold;

  logic [1:0]  res_status;
  logic [3:0]  res_client;
  logic [31:0] res_address;
  logic [15:0] res_port;

  slot_req_t slot_req;
  slot_t     slot_rd;
  link_req_t link_req;
  link_t     link_rd;

  nptl_slot_ram u_slot (.clk(clk), .req(slot_req), .rdata(slot_rd));
  nptl_link_ram u_link (.clk(clk), .req(link_req), .rdata(link_rd));

  // Configuration writes and reads
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_LOCAL_ADDR) ? local_address : {16'd0, first_port};

  always_ff @(posedge clk) begin
    if (rst) begin
      first_port    <= FIRST_PORT_RESET;
      local_address <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIRST_PORT) first_port <= pwdata[15:0];
      else                            local_address <= pwdata;
    end
  end

  // Request decode
  logic [1:0]  in_op;
  logic [3:0]  in_cl;
  logic [7:0]  in_pr;
  logic [31:0] in_ad;
  logic [15:0] in_po, in_s16;
  logic        in_proto_ok, accept;

  assign in_op  = s_tuser;
  assign in_cl  = s_tdata[3:0];
  assign in_pr  = s_tdata[11:4];
  assign in_ad  = s_tdata[43:12];
  assign in_po  = s_tdata[59:44];
  assign in_s16 = in_po - first_port;
  assign in_proto_ok = (in_pr == PROTO_ICMP) || (in_pr == PROTO_TCP) || (in_pr == PROTO_UDP);
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Pool capacity and helpers
  logic [16:0]      cap;
  logic             full, last_scan;
  slot_idx_t        scan_idx;
  logic [CNT_W-1:0] scan_inc;

  assign cap       = PORT_SPACE - {1'b0, first_port};
  assign full      = (17'(count) >= cap) || (count >= CNT_W'(POOL_SIZE));
  assign scan_idx  = scan[SLOT_W-1:0];
  assign scan_inc  = scan + CNT_W'(1);
  assign last_scan = (scan_inc == count);

  // Memory requests per state
  always_comb begin
    slot_req = '0;
    link_req = '0;
    case (state)
      S_OB_RD, S_RL_RD: begin
        slot_req.en   = 1'b1;
        slot_req.addr = scan_idx;
      end
      S_IN_RD: begin
        slot_req.en   = 1'b1;
        slot_req.addr = tgt;
      end
      S_WR_SLOT: begin
        slot_req.en    = 1'b1;
        slot_req.we    = 1'b1;
        slot_req.addr  = tgt;
        slot_req.wdata = '{valid: 1'b1, client: cl, protocol: pr, address: ad, port: po};
      end
      S_RL_CLR: begin
        slot_req.en          = 1'b1;
        slot_req.we          = 1'b1;
        slot_req.addr        = tgt;
        slot_req.wdata       = hold;
        slot_req.wdata.valid = 1'b0;
      end
      S_MV0: begin
        link_req.en   = 1'b1;
        link_req.addr = tgt;
      end
      S_MV1: begin
        link_req.en         = 1'b1;
        link_req.we_next    = 1'b1;
        link_req.addr       = link_rd.prev;
        link_req.wdata.next = link_rd.next;
      end
      S_MV2: begin
        link_req.en         = (tgt != tail);
        link_req.we_prev    = (tgt != tail);
        link_req.addr       = ln;
        link_req.wdata.prev = lp;
      end
      S_LF0: begin
        link_req.en         = 1'b1;
        link_req.we_prev    = 1'b1;
        link_req.we_next    = 1'b1;
        link_req.addr       = tgt;
        link_req.wdata.next = head;
      end
      S_LF1: begin
        link_req.en         = 1'b1;
        link_req.we_prev    = 1'b1;
        link_req.addr       = head;
        link_req.wdata.prev = tgt;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_DONE;
      count    <= '0;
      head     <= '0;
      tail     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cl <= in_cl; pr <= in_pr; ad <= in_ad; po <= in_po;
            scan        <= '0;
            res_client  <= 4'd0;
            res_address <= 32'd0;
            res_port    <= 16'd0;
            if (in_op == OP_REL) begin
              res_status <= ST_REL;
              state      <= (count == '0) ? S_DONE : S_RL_RD;
            end else if (in_op == OP_OUT && in_proto_ok) begin
              res_status <= ST_OK;
              state      <= (count == '0) ? S_ALLOC : S_OB_RD;
            end else if (in_op == OP_IN && in_proto_ok) begin
              tgt <= in_s16[SLOT_W-1:0];
              if (in_ad == local_address && 17'(in_s16) < 17'(count)) begin
                res_status <= ST_OK;
                state      <= S_IN_RD;
              end else begin
                res_status <= ST_MISS;
                state      <= S_DONE;
              end
            end else begin
              res_status <= ST_UNSUP;
              state      <= S_DONE;
            end
          end
        end
        S_OB_RD: state <= S_OB_CHK;
        S_OB_CHK: begin
          if (slot_rd.valid && slot_rd.client == cl && slot_rd.protocol == pr &&
              slot_rd.address == ad && slot_rd.port == po) begin
            res_address <= local_address;
            res_port    <= first_port + 16'(scan_idx);
            state       <= S_DONE;
          end else begin
            scan  <= scan_inc;
            state <= last_scan ? S_ALLOC : S_OB_RD;
          end
        end
        S_ALLOC: begin
          ret <= S_WR_SLOT;
          if (full) begin
            tgt   <= tail;
            state <= (tail == head) ? S_WR_SLOT : S_MV0;
          end else begin
            tgt   <= count[SLOT_W-1:0];
            count <= count + CNT_W'(1);
            if (count == '0) begin
              head  <= count[SLOT_W-1:0];
              tail  <= count[SLOT_W-1:0];
              state <= S_WR_SLOT;
            end else begin
              state <= S_LF0;
            end
          end
        end
        S_WR_SLOT: begin
          res_address <= local_address;
          res_port    <= first_port + 16'(tgt);
          state       <= S_DONE;
        end
        S_IN_RD: state <= S_IN_CHK;
        S_IN_CHK: begin
          if (slot_rd.valid && slot_rd.protocol == pr) begin
            res_client  <= slot_rd.client;
            res_address <= slot_rd.address;
            res_port    <= slot_rd.port;
            ret         <= S_DONE;
            state       <= (tgt == head) ? S_DONE : S_MV0;
          end else begin
            res_status <= ST_MISS;
            state      <= S_DONE;
          end
        end
        S_RL_RD: begin
          tgt   <= scan_idx;
          state <= S_RL_CHK;
        end
        S_RL_CHK: begin
          if (slot_rd.valid && slot_rd.client == cl) begin
            hold  <= slot_rd;
            ret   <= S_RL_CLR;
            state <= (tgt == head) ? S_RL_CLR : S_MV0;
          end else begin
            scan  <= scan_inc;
            state <= last_scan ? S_DONE : S_RL_RD;
          end
        end
        S_RL_CLR: begin
          scan  <= scan_inc;
          state <= last_scan ? S_DONE : S_RL_RD;
        end
        // unlink tgt, then relink it at the front
        S_MV0: state <= S_MV1;
        S_MV1: begin
          lp    <= link_rd.prev;
          ln    <= link_rd.next;
          state <= S_MV2;
        end
        S_MV2: begin
          if (tgt == tail) tail <= lp;
          state <= S_LF0;
        end
        S_LF0: state <= S_LF1;
        S_LF1: begin
          head  <= tgt;
          state <= ret;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {4'd0, res_port, res_address, res_client};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the table bookkeeping and result handoff
  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(POOL_SIZE))
  `ASSERT_IMPLIES(a_head_live, count != '0, CNT_W'(head) < count)
  `ASSERT_IMPLIES(a_tail_live, count != '0, CNT_W'(tail) < count)
  `ASSERT_NEXT(a_done_emits, state == S_DONE && (!m_tvalid || m_tready), m_tvalid)

endmodule

// ----- tb/nat_port_table_lru_test.sv -----
// Self-checking bench for the port translation table (nat_port_table_lru).
// Depends on nptl_pkg and the RTL; a built-in LRU table model predicts the random results.
`timescale 1ns / 1ps

module nat_port_table_lru_test;
  import nptl_pkg::*;

  localparam int TABLE_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int STALL_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  client;
    logic [31:0] address;
    logic [15:0] port;
  } xlate_t;

  typedef struct packed {
    logic [3:0]  client;
    logic [7:0]  protocol;
    logic [31:0] address;
    logic [15:0] port;
  } flow_t;

  typedef struct packed {
    logic [1:0]  op;
    flow_t       flow;
    bit          typed;
    xlate_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;   // client_id[3:0], protocol[11:4], address[43:12], port[59:44]
  logic [1:0]  s_tuser;   // operation
  logic        m_tvalid, m_tready;
  logic [55:0] m_tdata;   // out_client[3:0], out_address[35:4], out_port[51:36]
  logic [1:0]  m_tuser;   // status

  nat_port_table_lru dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Table model state
  logic [15:0] cfg_first_port;
  logic [31:0] cfg_local_addr;
  bit          slot_live [TABLE_SLOTS];
  flow_t       slot_flow [TABLE_SLOTS];
  int unsigned link_prev [TABLE_SLOTS];
  int unsigned link_next [TABLE_SLOTS];
  int unsigned lru_head, lru_tail, slots_used;

  xlate_t      pending_xlates[$];
  flow_t       recent_flows[$];
  int          errors, requests, results, inbound_hits, evictions, releases;
  int          cycles;
  bit          calm;
  bit          stall_req;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_xlates.size());
      $display("FAIL");
      $finish;
    end
  end

  // Flip between stretches with and without idling
  initial begin
    calm = 0;
    forever begin
      repeat ($urandom_range(100, 500)) @(negedge clk);
      calm = ~calm;
    end
  end

  function automatic int unsigned pool_capacity();
    int unsigned c;
    c = 32'h10000 - cfg_first_port;
    return (c > TABLE_SLOTS) ? TABLE_SLOTS : c;
  endfunction

  function automatic void lru_link_front(int unsigned s);
    link_prev[s] = 0;
    link_next[s] = lru_head;
    link_prev[lru_head] = s;
    lru_head = s;
  endfunction

  function automatic void lru_touch(int unsigned s);
    int unsigned p, n;
    if (s == lru_head) return;
    p = link_prev[s];
    n = link_next[s];
    link_next[p] = n;
    if (s == lru_tail) lru_tail = p;
    else link_prev[n] = p;
    lru_link_front(s);
  endfunction

  function automatic bit proto_supported(logic [7:0] p);
    return p == PROTO_ICMP || p == PROTO_TCP || p == PROTO_UDP;
  endfunction

  // Work out one result and update the table model
  function automatic xlate_t translate(logic [1:0] op, flow_t f);
    xlate_t r;
    int unsigned s;
    r = '0;
    if (op == OP_REL) begin
      for (s = 0; s < slots_used; s++) begin
        if (slot_live[s] && slot_flow[s].client == f.client) begin
          lru_touch(s);
          slot_live[s] = 0;
        end
      end
      releases++;
      r.status = ST_REL;
      return r;
    end
    if (!(op == OP_OUT || op == OP_IN) || !proto_supported(f.protocol)) begin
      r.status = ST_UNSUP;
      return r;
    end
    if (op == OP_IN) begin
      s = 32'(16'(f.port - cfg_first_port));
      if (f.address == cfg_local_addr && s < slots_used && slot_live[s] &&
          slot_flow[s].protocol == f.protocol) begin
        lru_touch(s);
        inbound_hits++;
        r.status  = ST_OK;
        r.client  = slot_flow[s].client;
        r.address = slot_flow[s].address;
        r.port    = slot_flow[s].port;
      end else begin
        r.status = ST_MISS;
      end
      return r;
    end
    // outbound: existing mapping first
    for (s = 0; s < slots_used; s++) begin
      if (slot_live[s] && slot_flow[s] == f) begin
        r.status  = ST_OK;
        r.address = cfg_local_addr;
        r.port    = 16'(cfg_first_port + s);
        return r;
      end
    end
    if (slots_used >= pool_capacity()) begin
      s = lru_tail;
      lru_touch(s);
      evictions++;
    end else begin
      s = slots_used;
      if (slots_used == 0) begin
        lru_head = s;
        lru_tail = s;
        link_prev[s] = 0;
        link_next[s] = 0;
      end else begin
        lru_link_front(s);
      end
      slots_used++;
    end
    slot_live[s] = 1;
    slot_flow[s] = f;
    r.status  = ST_OK;
    r.address = cfg_local_addr;
    r.port    = 16'(cfg_first_port + s);
    return r;
  endfunction

  task automatic report(string what, logic [31:0] want, logic [31:0] got);
    $display("[%0d] mismatch %s: expected %h, got %h", cycles, what, want, got);
    errors++;
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    xlate_t want;
    if (!rst && m_tvalid && m_tready) begin
      results++;
      if (pending_xlates.size() == 0) begin
        report("unexpected result", 32'd0, {m_tuser, m_tdata[29:0]});
      end else begin
        want = pending_xlates.pop_front();
        if (m_tuser !== want.status)
          report("status", 32'(want.status), 32'(m_tuser));
        if (m_tdata[3:0] !== want.client)
          report("client", 32'(want.client), 32'(m_tdata[3:0]));
        if (m_tdata[35:4] !== want.address)
          report("address", want.address, m_tdata[35:4]);
        if (m_tdata[51:36] !== want.port)
          report("port", 32'(want.port), 32'(m_tdata[51:36]));
        if (m_tdata[55:52] !== 4'b0)
          report("tdata pad", 32'd0, 32'(m_tdata[55:52]));
      end
    end
  end

  // Result side: random backpressure plus one long hold-off on request
  initial begin
    int r;
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 0;
        m_tready = 0;
        repeat (STALL_CYCLES) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      if (calm || r < 70) begin
        m_tready = 1;
      end else if (r < 97) begin
        m_tready = 0;
      end else begin
        m_tready = 0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // Offer one request, predict it on acceptance, then sometimes idle a while
  task automatic send_request(logic [1:0] op, flow_t f, bit typed, xlate_t want);
    xlate_t got;
    int r;
    s_tuser  = op;
    s_tdata  = {4'b0, f.port, f.address, f.protocol, f.client};
    s_tvalid = 1;
    do @(posedge clk); while (!s_tready);
    got = translate(op, f);
    pending_xlates.push_back(typed ? want : got);
    requests++;
    @(negedge clk);
    r = $urandom_range(0, 99);
    if (!calm && r >= 60) begin
      s_tvalid = 0;
      repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid = 0;
    while (pending_xlates.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic reg_index, logic [31:0] value);
    wait_idle();
    psel = 1; pwrite = 1; penable = 0;
    paddr = {reg_index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    if (reg_index == REG_FIRST_PORT) cfg_first_port = value[15:0];
    else cfg_local_addr = value;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(0, 2))
      0: return PROTO_ICMP;
      1: return PROTO_TCP;
      default: return PROTO_UDP;
    endcase
  endfunction

  // Mostly well-formed traffic: reused flows, inbound hits on live slots
  task automatic random_requests(int count);
    flow_t f;
    logic [1:0] op;
    int r, s;
    repeat (count) begin
      r = $urandom_range(0, 99);
      f = 60'({$urandom, $urandom});
      if (r < 45) begin
        op = OP_OUT;
        if (recent_flows.size() > 0 && $urandom_range(0, 9) < 6) begin
          f = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
        end else begin
          f.client = 4'($urandom_range(0, 15));
          f.protocol = pick_proto();
          recent_flows.push_back(f);
          if (recent_flows.size() > 24) void'(recent_flows.pop_front());
        end
      end else if (r < 75) begin
        op = OP_IN;
        f.protocol = pick_proto();
        if (slots_used > 0 && $urandom_range(0, 9) < 8) begin
          s = $urandom_range(0, slots_used - 1);
          f.port = 16'(cfg_first_port + s);
          if ($urandom_range(0, 9) < 9) f.address = cfg_local_addr;
          if (slot_live[s] && $urandom_range(0, 9) < 8) f.protocol = slot_flow[s].protocol;
        end
      end else if (r < 85) begin
        op = OP_REL;
      end else begin
        op = 2'($urandom_range(0, 3));
        f.protocol = (r < 92) ? 8'($urandom) : pick_proto();
      end
      send_request(op, f, 0, '0);
    end
  endtask

  // Directed rows; expectations typed where they are obvious
  function automatic dir_row_t row(logic [1:0] op, logic [3:0] cl, logic [7:0] pr,
                                   logic [31:0] ad, logic [15:0] po, logic [1:0] st,
                                   logic [3:0] ocl, logic [31:0] oad, logic [15:0] opo);
    dir_row_t d;
    d.op = op;
    d.flow = '{cl, pr, ad, po};
    d.typed = 1;
    d.want = '{st, ocl, oad, opo};
    return d;
  endfunction

  initial begin
    dir_row_t dir_rows[$];
    clk = 0; rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    s_tvalid = 0; s_tdata = '0; s_tuser = OP_OUT;
    errors = 0; requests = 0; results = 0; cycles = 0;
    inbound_hits = 0; evictions = 0; releases = 0; stall_req = 0;
    cfg_first_port = FIRST_PORT_RESET;
    cfg_local_addr = '0;
    slots_used = 0; lru_head = 0; lru_tail = 0;
    foreach (slot_live[i]) slot_live[i] = 0;

    // empty table, new mappings, hits, misses, unsupported, release
    dir_rows.push_back(row(OP_IN,  0, PROTO_TCP, 0, 64512, ST_MISS, 0, 0, 0));
    dir_rows.push_back(row(OP_OUT, 0, PROTO_TCP, 0, 0, ST_OK, 0, 0, 64512));
    dir_rows.push_back(row(OP_OUT, 0, PROTO_TCP, 0, 0, ST_OK, 0, 0, 64512));
    dir_rows.push_back(row(OP_OUT, 15, PROTO_UDP, '1, '1, ST_OK, 0, 0, 64513));
    dir_rows.push_back(row(OP_OUT, 3, PROTO_ICMP, 32'h0a000001, 1234, ST_OK, 0, 0, 64514));
    dir_rows.push_back(row(OP_IN,  9, PROTO_UDP, 0, 64513, ST_OK, 15, '1, '1));
    dir_rows.push_back(row(OP_IN,  0, PROTO_TCP, 0, 64513, ST_MISS, 0, 0, 0));
    dir_rows.push_back(row(OP_IN,  0, PROTO_UDP, 1, 64513, ST_MISS, 0, 0, 0));
    dir_rows.push_back(row(OP_IN,  0, PROTO_ICMP, 0, 64514, ST_OK, 3, 32'h0a000001, 1234));
    dir_rows.push_back(row(OP_OUT, 0, 8'd0, 0, 0, ST_UNSUP, 0, 0, 0));
    dir_rows.push_back(row(OP_OUT, 15, 8'hff, '1, '1, ST_UNSUP, 0, 0, 0));
    dir_rows.push_back(row(OP_IN,  0, 8'd2, 0, 64512, ST_UNSUP, 0, 0, 0));
    dir_rows.push_back(row(2'd3,   0, PROTO_TCP, 0, 0, ST_UNSUP, 0, 0, 0));
    dir_rows.push_back(row(OP_REL, 15, 8'd99, '1, '1, ST_REL, 0, 0, 0));
    dir_rows.push_back(row(OP_IN,  0, PROTO_UDP, 0, 64513, ST_MISS, 0, 0, 0));
    dir_rows.push_back(row(OP_REL, 9, PROTO_TCP, 0, 0, ST_REL, 0, 0, 0));
    dir_rows.push_back(row(OP_OUT, 15, PROTO_UDP, '1, '1, ST_OK, 0, 0, 64515));
    dir_rows.push_back(row(OP_IN,  0, PROTO_TCP, 0, 16'hffff, ST_MISS, 0, 0, 0));
    dir_rows.push_back(row(OP_IN,  0, PROTO_TCP, 0, 0, ST_MISS, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (dir_rows[i]) send_request(dir_rows[i].op, dir_rows[i].flow, 1, dir_rows[i].want);

    // small pool; hold results off at the start so the input backs up
    write_reg(REG_FIRST_PORT, 32'd65528);
    write_reg(REG_LOCAL_ADDR, $urandom);
    stall_req = 1;
    random_requests(400);

    // single-slot pool at the top of the port range
    write_reg(REG_FIRST_PORT, 32'd65535);
    write_reg(REG_LOCAL_ADDR, 32'hffffffff);
    random_requests(150);

    write_reg(REG_FIRST_PORT, 32'd65520);
    write_reg(REG_LOCAL_ADDR, $urandom);
    random_requests(500);

    // full-size pool last, since allocated slots lengthen every scan
    write_reg(REG_FIRST_PORT, 32'(FIRST_PORT_RESET));
    write_reg(REG_LOCAL_ADDR, 32'd0);
    random_requests(200);

    s_tvalid = 0;
    while (pending_xlates.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("covered %0d requests and %0d results over four pool sizes", requests, results);
    $display("inbound hits %0d, LRU evictions %0d, client releases %0d",
             inbound_hits, evictions, releases);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
